>>> rtl/core/nrst_pkg.sv
// Package with request codes, the slot record type and the sequencer states.
package nrst_pkg;

	localparam int unsigned ADDR_W = 32;
	localparam int unsigned RES_W  = 16;
	localparam int unsigned PID_W  = 8;
	localparam int unsigned TASK_W = 16;
	localparam int unsigned MISS_W = 2;
	localparam int unsigned REQ_W  = 4;
	localparam int unsigned CFG_IDX_W = 1;
	localparam int unsigned SLOT_OUT_W = 4;
	localparam int unsigned SENT_W = 5;
	localparam logic [MISS_W-1:0] MISS_LIMIT = 2'd2;

	localparam logic [REQ_W-1:0] REQ_REGISTER      = 4'd0;
	localparam logic [REQ_W-1:0] REQ_IS_REGISTERED = 4'd1;
	localparam logic [REQ_W-1:0] REQ_STARTED       = 4'd2;
	localparam logic [REQ_W-1:0] REQ_FINISHED      = 4'd3;
	localparam logic [REQ_W-1:0] REQ_SET_TASKS     = 4'd4;
	localparam logic [REQ_W-1:0] REQ_GET_TASKS     = 4'd5;
	localparam logic [REQ_W-1:0] REQ_CLEAR_ALL     = 4'd6;
	localparam logic [REQ_W-1:0] REQ_BY_PREF_ID    = 4'd7;
	localparam logic [REQ_W-1:0] REQ_FIND_ELIGIBLE = 4'd8;
	localparam logic [REQ_W-1:0] REQ_TICK          = 4'd9;
	localparam logic [REQ_W-1:0] REQ_HB_RCVD       = 4'd10;
	localparam logic [REQ_W-1:0] REQ_REMOVE_FAILED = 4'd11;

	localparam logic [CFG_IDX_W-1:0] CFG_ARCH_OS_MASK = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MEM_MASK     = 1'd1;

	// One slot as kept in memory; valid and misses live in flip-flops.
	typedef struct packed {
		logic [ADDR_W-1:0] address;
		logic [RES_W-1:0]  resources;
		logic [PID_W-1:0]  pref_id;
		logic [TASK_W-1:0] tasks;
	} slot_rec_t;

	localparam int unsigned REC_W = $bits(slot_rec_t);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} seq_state_t;

endpackage

>>> rtl/core/nrst_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module nrst_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                                            clk,
	input  logic                                            we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]    waddr,
	input  logic [WIDTH-1:0]                                wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]    raddr,
	output logic [WIDTH-1:0]                                rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/core/node_registry_scheduler_table_top.sv
// Top level of the node registry: request sequencer around the slot memory.
// A request walks the table one slot per cycle behind the registered memory read; a full
// scan visits every slot, a first-match operation stops at the matching slot, and a
// find-eligible scan whose pointer is already past the last slot ends at once.
// One request at a time: the input is ready again in the cycle after the result is taken.
// Reset clears valid bits, miss counts, scan pointer and masks; the slot memory needs no
// clearing.
module node_registry_scheduler_table_top #(
	parameter int unsigned TABLE_ENTRIES = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [nrst_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [nrst_pkg::RES_W-1:0]          cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [nrst_pkg::REQ_W-1:0]          req_type,
	input  logic [nrst_pkg::ADDR_W-1:0]         node_address,
	input  logic [nrst_pkg::RES_W-1:0]          resource_bits,
	input  logic [nrst_pkg::PID_W-1:0]          pref_id,
	input  logic                                pref_id_given,
	input  logic signed [nrst_pkg::TASK_W-1:0]  task_value,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                ok,
	output logic [nrst_pkg::SLOT_OUT_W-1:0]     slot,
	output logic [nrst_pkg::ADDR_W-1:0]         found_address,
	output logic [nrst_pkg::RES_W-1:0]          found_resources,
	output logic [nrst_pkg::PID_W-1:0]          found_pref_id,
	output logic signed [nrst_pkg::TASK_W-1:0]  task_count,
	output logic [nrst_pkg::SENT_W-1:0]         sent_count,
	output logic                                list_empty
);

	localparam int unsigned IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int unsigned PW = $clog2(TABLE_ENTRIES + 1);
	localparam logic [IW:0] LAST = (IW + 1)'(TABLE_ENTRIES - 1);
	localparam int unsigned SENT_W_L = nrst_pkg::SENT_W;

	// Latched request and configuration.
	logic [nrst_pkg::REQ_W-1:0]  req_q;
	logic [nrst_pkg::ADDR_W-1:0] addr_q;
	logic [nrst_pkg::RES_W-1:0]  res_q;
	logic [nrst_pkg::PID_W-1:0]  pid_q;
	logic                        pidg_q;
	logic [nrst_pkg::TASK_W-1:0] tv_q;
	logic [nrst_pkg::RES_W-1:0]  arch_os_mask_q, mem_mask_q;

	logic [TABLE_ENTRIES-1:0] valid_q;
	logic [nrst_pkg::MISS_W-1:0] miss_q [TABLE_ENTRIES];
	logic [PW-1:0] scan_ptr_q;

	nrst_pkg::seq_state_t state_q, state_d;

	// The read index runs ahead of the compare stage: cmp_idx_s1 is rd_idx_q registered.
	logic [IW:0] rd_idx_q;   // address presented this cycle
	logic [IW:0] cmp_idx_s1; // index whose data is on rdata
	logic        cmp_vld_s1;
	logic        hit_q;
	logic [IW-1:0] hit_idx_q;
	nrst_pkg::slot_rec_t hit_rec_q;
	logic [SENT_W_L-1:0] cnt_q;

	nrst_pkg::slot_rec_t rdata, wdata;
	logic we;
	logic [IW-1:0] waddr;

	nrst_ram #(.WIDTH(nrst_pkg::REC_W), .DEPTH(TABLE_ENTRIES)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (rd_idx_q[IW-1:0]),
		.rdata (rdata)
	);

	// Compare stage: decide whether the slot on rdata matches the request.
	logic [IW-1:0] ci;
	logic cv, match;
	logic signed [nrst_pkg::TASK_W-1:0] st, lim;
	always_comb begin
		ci  = cmp_idx_s1[IW-1:0];
		cv  = cmp_vld_s1 && valid_q[ci];
		st  = rdata.tasks;
		lim = tv_q;
		match = 1'b0;
		unique case (req_q)
			nrst_pkg::REQ_REGISTER:      match = cmp_vld_s1 && !valid_q[ci];
			nrst_pkg::REQ_IS_REGISTERED, nrst_pkg::REQ_STARTED,
			nrst_pkg::REQ_FINISHED, nrst_pkg::REQ_SET_TASKS,
			nrst_pkg::REQ_GET_TASKS, nrst_pkg::REQ_HB_RCVD:
				match = cv && (rdata.address == addr_q);
			nrst_pkg::REQ_BY_PREF_ID:    match = cv && pidg_q && (rdata.pref_id == pid_q);
			nrst_pkg::REQ_FIND_ELIGIBLE:
				match = cv && (st <= lim)
					&& ((rdata.resources & arch_os_mask_q) == (res_q & arch_os_mask_q))
					&& ((rdata.resources & mem_mask_q) >= (res_q & mem_mask_q));
			nrst_pkg::REQ_REMOVE_FAILED: match = cv && (miss_q[ci] >= nrst_pkg::MISS_LIMIT);
			default:                     match = 1'b0;
		endcase
	end

	// Operations that stop at the first match versus those that sweep everything.
	logic sweep_all;
	assign sweep_all = (req_q == nrst_pkg::REQ_SET_TASKS) || (req_q == nrst_pkg::REQ_HB_RCVD)
		|| (req_q == nrst_pkg::REQ_CLEAR_ALL) || (req_q == nrst_pkg::REQ_TICK);
	logic stop;
	assign stop = match && !sweep_all;
	logic last_cmp;
	assign last_cmp = cmp_vld_s1 && (cmp_idx_s1 == LAST);

	// Write-back of the compared slot.
	always_comb begin
		we    = 1'b0;
		waddr = ci;
		wdata = rdata;
		if (state_q == nrst_pkg::ST_SCAN && cmp_vld_s1 && !hit_q) begin
			unique case (req_q)
				nrst_pkg::REQ_REGISTER: if (match) begin
					we = 1'b1;
					wdata.address = addr_q; wdata.resources = res_q;
					wdata.pref_id = pid_q;  wdata.tasks = '0;
				end
				nrst_pkg::REQ_STARTED: if (match) begin
					we = 1'b1; wdata.tasks = rdata.tasks + 1'b1;
				end
				nrst_pkg::REQ_FINISHED: if (match) begin
					we = 1'b1; wdata.tasks = rdata.tasks - 1'b1;
				end
				nrst_pkg::REQ_CLEAR_ALL: begin
					we = 1'b1; wdata.tasks = '0;
				end
				nrst_pkg::REQ_REMOVE_FAILED: if (match) begin
					we = 1'b1; wdata.tasks = '0; wdata.resources = '0;
				end
				default: we = 1'b0;
			endcase
		end
		if (state_q == nrst_pkg::ST_SCAN && cmp_vld_s1 && hit_q
			&& req_q == nrst_pkg::REQ_SET_TASKS && match) begin
			we = 1'b1; wdata.tasks = tv_q;
		end
		if (state_q == nrst_pkg::ST_SCAN && cmp_vld_s1 && !hit_q
			&& req_q == nrst_pkg::REQ_SET_TASKS && match) begin
			we = 1'b1; wdata.tasks = tv_q;
		end
	end

	// A scan ends at the first match of a first-match operation, at the last slot, or at once when a
	// find-eligible scan starts with its pointer already past the last slot.
	logic done_scan;
	assign done_scan = (cmp_vld_s1 && (stop || last_cmp)) || (!cmp_vld_s1 && (rd_idx_q > LAST));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			nrst_pkg::ST_IDLE: if (in_valid) state_d = nrst_pkg::ST_SCAN;
			nrst_pkg::ST_SCAN: if (done_scan) state_d = nrst_pkg::ST_DONE;
			nrst_pkg::ST_DONE: if (out_ready) state_d = nrst_pkg::ST_IDLE;
			default:           state_d = nrst_pkg::ST_IDLE;
		endcase
	end
	assign in_ready  = (state_q == nrst_pkg::ST_IDLE);
	assign out_valid = (state_q == nrst_pkg::ST_DONE);

	logic [PW-1:0] start_idx;
	assign start_idx = (req_type == nrst_pkg::REQ_FIND_ELIGIBLE) ? scan_ptr_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= nrst_pkg::ST_IDLE;
			valid_q <= '0;
			for (int i = 0; i < TABLE_ENTRIES; i++) miss_q[i] <= '0;
			scan_ptr_q <= '0;
			arch_os_mask_q <= '0;
			mem_mask_q <= '0;
			cmp_vld_s1 <= 1'b0;
			hit_q <= 1'b0;
			req_q <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				unique case (cfg_index)
					nrst_pkg::CFG_ARCH_OS_MASK: arch_os_mask_q <= cfg_data;
					nrst_pkg::CFG_MEM_MASK:     mem_mask_q <= cfg_data;
					default: ;
				endcase
			end
			if (state_q == nrst_pkg::ST_IDLE && in_valid) begin
				req_q <= req_type;
				hit_q <= 1'b0;
				// No slot is on rdata yet, so the compare starts invalid; a pointer at
				// the end keeps it so and gives an empty scan in which nothing matches.
				cmp_vld_s1 <= 1'b0;
			end
			if (state_q == nrst_pkg::ST_SCAN) begin
				cmp_vld_s1 <= !done_scan && (rd_idx_q <= LAST);
				if (cmp_vld_s1 && match && !hit_q) hit_q <= 1'b1;
				if (cmp_vld_s1) begin
					if (req_q == nrst_pkg::REQ_REGISTER && match && !hit_q)
						valid_q[ci] <= 1'b1;
					if (req_q == nrst_pkg::REQ_REMOVE_FAILED && match && !hit_q)
						valid_q[ci] <= 1'b0;
					if (req_q == nrst_pkg::REQ_REGISTER && match && !hit_q)
						miss_q[ci] <= '0;
					if (req_q == nrst_pkg::REQ_HB_RCVD && match)
						miss_q[ci] <= '0;
					if (req_q == nrst_pkg::REQ_TICK) begin
						if (!valid_q[ci]) miss_q[ci] <= '0;
						else if (miss_q[ci] < nrst_pkg::MISS_LIMIT)
							miss_q[ci] <= miss_q[ci] + 1'b1;
					end
					if (req_q == nrst_pkg::REQ_FIND_ELIGIBLE && done_scan)
						scan_ptr_q <= match ? PW'(cmp_idx_s1 + 1'b1) : '0;
				end
				// Empty find-eligible scan (pointer already at the end).
				if (req_q == nrst_pkg::REQ_FIND_ELIGIBLE && !cmp_vld_s1
					&& rd_idx_q > LAST)
					scan_ptr_q <= '0;
			end
		end
	end

	// Request fields, the read index and the result record. A removed slot
	// reports its contents from before the removal.
	always_ff @(posedge clk) begin
		if (state_q == nrst_pkg::ST_IDLE && in_valid) begin
			addr_q <= node_address;
			res_q  <= resource_bits;
			pid_q  <= pref_id;
			pidg_q <= pref_id_given;
			tv_q   <= task_value;
			rd_idx_q <= (IW + 1)'(start_idx);
			cnt_q <= '0;
		end else if (state_q == nrst_pkg::ST_SCAN) begin
			if (rd_idx_q <= LAST) rd_idx_q <= rd_idx_q + 1'b1;
			if (cmp_vld_s1 && valid_q[ci]) cnt_q <= cnt_q + 1'b1;
			if (cmp_vld_s1 && match && !hit_q) begin
				hit_idx_q <= ci;
				hit_rec_q <= (we && req_q != nrst_pkg::REQ_REMOVE_FAILED) ? wdata : rdata;
			end
		end
		cmp_idx_s1 <= rd_idx_q;
	end

	// Output fields, zero where they carry no meaning.
	logic got;
	assign got = hit_q && (req_q != nrst_pkg::REQ_CLEAR_ALL) && (req_q != nrst_pkg::REQ_TICK);
	logic info;
	assign info = (req_q == nrst_pkg::REQ_CLEAR_ALL) || (req_q == nrst_pkg::REQ_TICK);
	assign ok              = got || info;
	assign slot            = got ? nrst_pkg::SLOT_OUT_W'(hit_idx_q) : '0;
	assign found_address   = got ? hit_rec_q.address : '0;
	assign found_resources = got ? hit_rec_q.resources : '0;
	assign found_pref_id   = got ? hit_rec_q.pref_id : '0;
	assign task_count      = got ? hit_rec_q.tasks : '0;
	assign sent_count      = (req_q == nrst_pkg::REQ_TICK) ? cnt_q : '0;
	assign list_empty      = ~|valid_q;

endmodule
